// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on the block clock, off while reset is active
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, with an extra disable term
`define ASSERT_CLK_IF(lbl, dis, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni || (dis)) prop) else $error(msg);

`endif

// ===== rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared constants and types of the ray / box slab intersection core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbsi_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned NUM_AXES        = 3;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MIN_Z  = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5
  } reg_idx_e;

  // per-slab control bits that ride along the divider pipe
  typedef struct packed {
    logic neg;      // sign of the low-plane quotient
    logic dz;       // direction component is zero
    logic in_slab;  // origin lies within the slab
    logic below;    // origin lies below the slab
  } slab_tag_t;

  localparam int unsigned TAG_W = $bits(slab_tag_t);

endpackage

// ===== rtl/rbsi_div.sv =====
// ----------------------------------------------------------------------------
// rbsi_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbsi_div #(
  parameter int unsigned CW   = 32,
  parameter int unsigned FB   = 16,
  parameter int unsigned SB_W = 1
) (
  input  logic            clk_i,
  input  logic [CW:0]     mag_i,   // dividend magnitude, scaled by 2^FB inside
  input  logic [CW-1:0]   dm_i,    // divisor magnitude
  input  logic [SB_W-1:0] sb_i,
  output logic [CW-1:0]   q_o,
  output logic            ovf_o,   // quotient reaches 2^(CW-1)
  output logic [SB_W-1:0] sb_o
);

  localparam int unsigned STEPS = CW + FB + 1;

  logic [CW:0]     r_q   [STEPS];
  logic [CW-1:0]   q_q   [STEPS];
  logic            sat_q [STEPS];
  logic [CW:0]     mag_q [STEPS];
  logic [CW-1:0]   dm_q  [STEPS];
  logic [SB_W-1:0] sb_q  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    localparam int unsigned I = STEPS - 1 - s;
    logic [CW:0]     r_in, rs, r_d;
    logic [CW-1:0]   q_in, dm_in;
    logic [CW:0]     mag_in;
    logic            sat_in, bitv, ge;
    logic [SB_W-1:0] sb_in;

    if (s == 0) begin : g_first
      assign r_in   = '0;
      assign q_in   = '0;
      assign sat_in = 1'b0;
      assign mag_in = mag_i;
      assign dm_in  = dm_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign r_in   = r_q[s-1];
      assign q_in   = q_q[s-1];
      assign sat_in = sat_q[s-1];
      assign mag_in = mag_q[s-1];
      assign dm_in  = dm_q[s-1];
      assign sb_in  = sb_q[s-1];
    end

    // dividend bit entering this step, zero in the fraction tail
    if (I >= FB) begin : g_bit
      assign bitv = mag_in[I-FB];
    end else begin : g_zero
      assign bitv = 1'b0;
    end

    // one compare and subtract
    always_comb begin
      rs  = {r_in[CW-1:0], bitv};
      ge  = (rs >= {1'b0, dm_in});
      r_d = ge ? (rs - {1'b0, dm_in}) : rs;
    end

    always_ff @(posedge clk_i) begin
      r_q[s]   <= r_d;
      q_q[s]   <= {q_in[CW-2:0], ge};
      sat_q[s] <= sat_in | q_in[CW-1];
      mag_q[s] <= mag_in;
      dm_q[s]  <= dm_in;
      sb_q[s]  <= sb_in;
    end
  end

  assign q_o   = q_q[STEPS-1];
  assign ovf_o = sat_q[STEPS-1] | q_q[STEPS-1][CW-1];
  assign sb_o  = sb_q[STEPS-1];

endmodule

// ===== rtl/rbsi_slab.sv =====
// ----------------------------------------------------------------------------
// rbsi_slab
// one axis: plane offsets, two slab distance dividers, interval sort
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbsi_slab #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic signed [CW-1:0] box_min_i,
  input  logic [CW-2:0]        box_size_i,
  input  logic signed [CW-1:0] origin_i,
  input  logic signed [CW-1:0] dir_i,
  output logic signed [CW-1:0] a_o,     // interval start
  output logic signed [CW-1:0] b_o,     // interval end
  output logic                 miss_o
);
  import rbsi_pkg::*;

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // plane offsets and divider operands
  logic signed [CW+1:0] nlo, nhi, alo, ahi;
  logic [CW-1:0]        dm_d;
  slab_tag_t            tag_d;
  logic                 neg_hi_d;

  always_comb begin
    nlo  = (CW+2)'(box_min_i) - (CW+2)'(origin_i);
    nhi  = nlo + $signed({3'b000, box_size_i});
    alo  = nlo[CW+1] ? -nlo : nlo;
    ahi  = nhi[CW+1] ? -nhi : nhi;
    dm_d = dir_i[CW-1] ? (CW)'(-dir_i) : dir_i;
    tag_d.neg     = nlo[CW+1] ^ dir_i[CW-1];
    tag_d.dz      = (dir_i == '0);
    tag_d.in_slab = (nlo[CW+1] || (nlo == '0)) && !nhi[CW+1];
    tag_d.below   = !nlo[CW+1];
    neg_hi_d      = nhi[CW+1] ^ dir_i[CW-1];
  end

  logic [CW:0]     mlo_q, mhi_q;
  logic [CW-1:0]   dm_q;
  slab_tag_t       tag_q;
  logic            neg_hi_q;

  always_ff @(posedge clk_i) begin
    mlo_q    <= alo[CW:0];
    mhi_q    <= ahi[CW:0];
    dm_q     <= dm_d;
    tag_q    <= tag_d;
    neg_hi_q <= neg_hi_d;
  end

  // low and high plane quotients
  logic [CW-1:0]    q_lo, q_hi;
  logic             ovf_lo, ovf_hi;
  logic [TAG_W-1:0] sb_lo;
  logic             sb_hi;
  slab_tag_t        tag_o;

  rbsi_div #(.CW(CW), .FB(FB), .SB_W(TAG_W)) u_div_lo (
    .clk_i (clk_i),
    .mag_i (mlo_q),
    .dm_i  (dm_q),
    .sb_i  (tag_q),
    .q_o   (q_lo),
    .ovf_o (ovf_lo),
    .sb_o  (sb_lo)
  );

  rbsi_div #(.CW(CW), .FB(FB), .SB_W(1)) u_div_hi (
    .clk_i (clk_i),
    .mag_i (mhi_q),
    .dm_i  (dm_q),
    .sb_i  (neg_hi_q),
    .q_o   (q_hi),
    .ovf_o (ovf_hi),
    .sb_o  (sb_hi)
  );

  // sign and saturate a quotient magnitude
  function automatic logic signed [CW-1:0] sat_val(input logic [CW-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
    logic signed [CW-1:0] v;
    if (neg) begin
      v = ovf ? MINV : -$signed(q);
    end else begin
      v = ovf ? MAXV : $signed(q);
    end
    return v;
  endfunction

  // slab interval, zero direction handled apart
  logic signed [CW-1:0] t1, t2, a_d, b_d;
  logic                 miss_d;

  always_comb begin
    tag_o  = slab_tag_t'(sb_lo);
    t1     = sat_val(q_lo, ovf_lo, tag_o.neg);
    t2     = sat_val(q_hi, ovf_hi, sb_hi);
    a_d    = (t1 < t2) ? t1 : t2;
    b_d    = (t1 < t2) ? t2 : t1;
    miss_d = 1'b0;
    if (tag_o.dz) begin
      if (tag_o.in_slab) begin
        a_d = MINV;
        b_d = MAXV;
      end else if (tag_o.below) begin
        a_d    = MAXV;
        b_d    = MAXV;
        miss_d = 1'b1;
      end else begin
        a_d    = MINV;
        b_d    = MINV;
        miss_d = 1'b1;
      end
    end
  end

  logic signed [CW-1:0] a_q, b_q;
  logic                 miss_q;

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    miss_q <= miss_d;
  end

  assign a_o    = a_q;
  assign b_o    = b_q;
  assign miss_o = miss_q;

endmodule

// ===== rtl/ray_box_slab_intersect_core.sv =====
// from start to done_o a ray passes the input capture, plane offset registers, the
// divider pipe that retires one quotient bit per stage, slab and result registers
// throughput: one ray per cycle, busy is always low and results are never held
// reset: rst_ni clears the valid pipe and the box registers to zero
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core
// fixed point ray against axis aligned box test, slab method, fully pipelined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_box_slab_intersect_core #(
  parameter int unsigned COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
  localparam int unsigned APB_DW     = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int unsigned ADDR_SH    = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int unsigned APB_AW     = ADDR_SH + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready,
  // ray beat
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  // result beat
  output logic                          done_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] t_enter_o,
  output logic signed [COORD_WIDTH-1:0] t_exit_o
);
  import rbsi_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned LAT = COORD_WIDTH + FRAC_BITS + 5;

  // box registers
  logic signed [CW-1:0] min_q  [NUM_AXES];
  logic [CW-2:0]        size_q [NUM_AXES];
  reg_idx_e             idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:ADDR_SH]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        min_q[k]  <= '0;
        size_q[k] <= '0;
      end
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_X:  min_q[0]  <= pwdata[CW-1:0];
        REG_MIN_Y:  min_q[1]  <= pwdata[CW-1:0];
        REG_MIN_Z:  min_q[2]  <= pwdata[CW-1:0];
        REG_SIZE_X: size_q[0] <= pwdata[CW-2:0];
        REG_SIZE_Y: size_q[1] <= pwdata[CW-2:0];
        REG_SIZE_Z: size_q[2] <= pwdata[CW-2:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (idx)
      REG_MIN_X:  prdata = APB_DW'(min_q[0]);
      REG_MIN_Y:  prdata = APB_DW'(min_q[1]);
      REG_MIN_Z:  prdata = APB_DW'(min_q[2]);
      REG_SIZE_X: prdata = APB_DW'(size_q[0]);
      REG_SIZE_Y: prdata = APB_DW'(size_q[1]);
      REG_SIZE_Z: prdata = APB_DW'(size_q[2]);
      default:    prdata = '0;
    endcase
  end

  // input capture
  logic signed [CW-1:0] org_q [NUM_AXES];
  logic signed [CW-1:0] dir_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    org_q[0] <= origin_x_i;
    org_q[1] <= origin_y_i;
    org_q[2] <= origin_z_i;
    dir_q[0] <= dir_x_i;
    dir_q[1] <= dir_y_i;
    dir_q[2] <= dir_z_i;
  end

  // valid pipe in step with the data
  logic [LAT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], start & ~busy};
    end
  end

  // per-axis slabs
  logic signed [CW-1:0] a_s [NUM_AXES];
  logic signed [CW-1:0] b_s [NUM_AXES];
  logic [NUM_AXES-1:0]  miss_s;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    rbsi_slab #(.CW(CW), .FB(FRAC_BITS)) u_slab (
      .clk_i      (clk_i),
      .box_min_i  (min_q[k]),
      .box_size_i (size_q[k]),
      .origin_i   (org_q[k]),
      .dir_i      (dir_q[k]),
      .a_o        (a_s[k]),
      .b_o        (b_s[k]),
      .miss_o     (miss_s[k])
    );
  end

  // entry is the latest start, exit the earliest end
  logic signed [CW-1:0] enter_d, exit_d;
  logic                 hit_d;

  always_comb begin
    enter_d = a_s[0];
    exit_d  = b_s[0];
    for (int k = 1; k < NUM_AXES; k++) begin
      if (a_s[k] > enter_d) enter_d = a_s[k];
      if (b_s[k] < exit_d)  exit_d  = b_s[k];
    end
    hit_d = ~(|miss_s) && !exit_d[CW-1] && (exit_d >= enter_d);
  end

  logic                 hit_q;
  logic signed [CW-1:0] enter_q, exit_q;

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    enter_q <= enter_d;
    exit_q  <= exit_d;
  end

  assign done_o    = valid_q[LAT-1];
  assign hit_o     = hit_q;
  assign t_enter_o = enter_q;
  assign t_exit_o  = exit_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_ray_done, (start && !busy) |-> ##LAT done_o, "accepted ray gave no result")
  `ASSERT_CLK(a_hit_order, (done_o && hit_o) |-> (t_exit_o >= t_enter_o), "hit with exit before entry")
  `ASSERT_CLK_IF(a_hit_ahead, !done_o, hit_o |-> !t_exit_o[CW-1], "hit with negative exit")

endmodule
